// File: sv/ethernet_ipv4_rx_classifier_unit_macros.svh
// Assertion macros shared by the receive classifier modules.
// Depends on nothing; included inside module bodies.
`ifndef ETHERNET_IPV4_RX_CLASSIFIER_UNIT_MACROS_SVH
`define ETHERNET_IPV4_RX_CLASSIFIER_UNIT_MACROS_SVH
// implication checked on every clock, idle in reset
`define EIRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define EIRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: sv/eirc_pkg.sv
// Package for the Ethernet/IPv4 receive classifier: types, codes, limits.
// No dependencies.
package eirc_pkg;
	localparam int ArpEntriesDef = 8;
	localparam int MinFrameDef = 60;
	localparam int MaxFrameDef = 1514;
	localparam int NumPortsDef = 4;
	localparam int CapBytes = 42;
	localparam int QDepth = 2;

	typedef enum logic [3:0] {
		V_BAD_SIZE = 4'd0, V_ADDR_MISS = 4'd1, V_OTHER_ETYPE = 4'd2, V_IP_HDR = 4'd3,
		V_NOT_LOCAL = 4'd4, V_OTHER_PROTO = 4'd5, V_ICMP_OTHER = 4'd6, V_ICMP_ECHO = 4'd7,
		V_UDP_MISS = 4'd8, V_UDP_OK = 4'd9, V_ARP_IGN = 4'd10, V_ARP_LEARN = 4'd11,
		V_ARP_REPLY = 4'd12
	} verdict_t;

	typedef enum logic [2:0] {
		R_LOCAL_MAC = 3'd0, R_LOCAL_IP = 3'd1, R_MODE = 3'd2, R_PORT_CNT = 3'd3,
		R_PORT0 = 3'd4, R_PORT1 = 3'd5, R_PORT2 = 3'd6, R_PORT3 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  verdict;
		logic [47:0] remote_mac;
		logic [31:0] remote_ip;
		logic [15:0] remote_port;
		logic [1:0]  port_index;
		logic [10:0] payload_length;
		logic [2:0]  arp_index;
		logic        arp_table_full;
		logic [15:0] icmp_identifier;
		logic [15:0] icmp_sequence;
	} out_item_t;

	// front-to-back job: preclassified frame, ARP part still pending
	typedef struct packed {
		out_item_t   res;
		logic        is_arp;
		logic        arp_reply;
		logic [31:0] sip;
		logic [47:0] smac;
	} job_t;

	typedef enum logic [1:0] {BK_IDLE, BK_SEARCH, BK_OUT} bk_state_t;
endpackage

// File: sv/eirc_front.sv
// Front part: byte capture, length/address/ethertype/IP/UDP/ICMP/ARP checks.
// Uses eirc_pkg; feeds jobs into the queue.
module eirc_front #(
	parameter int MIN_FRAME_BYTES = eirc_pkg::MinFrameDef,
	parameter int MAX_FRAME_BYTES = eirc_pkg::MaxFrameDef,
	parameter int NUM_PORTS = eirc_pkg::NumPortsDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_acc,
	input  eirc_pkg::in_item_t in_item,
	input  logic [47:0]        local_mac,
	input  logic [31:0]        local_ip,
	input  logic [1:0]         accept_mode,
	input  logic [2:0]         port_cnt,
	input  logic [63:0]        ports,
	output logic               job_valid,
	output eirc_pkg::job_t     job
);
	import eirc_pkg::*;

	logic [10:0] pos_q;
	logic [7:0]  cap_q [CapBytes];
	logic [7:0]  h [CapBytes];
	logic [11:0] len;
	logic [15:0] etype, total, ulen, dport;
	logic [2:0]  cnt;
	logic        hit;
	logic [1:0]  hidx;
	job_t        j;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_acc) begin
			if (in_item.frame_end) pos_q <= '0;
			else if (pos_q != 11'h7FF) pos_q <= pos_q + 11'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && pos_q < 11'(CapBytes)) cap_q[pos_q[5:0]] <= in_item.rx_byte;
	end

	// last byte may land in the capture the same cycle
	always_comb begin
		for (int k = 0; k < CapBytes; k++)
			h[k] = (pos_q == 11'(k)) ? in_item.rx_byte : cap_q[k];
	end

	always_comb begin
		len = {1'b0, pos_q} + 12'd1;
		etype = {h[12], h[13]};
		total = {h[16], h[17]};
		dport = {h[36], h[37]};
		ulen = {h[38], h[39]};
		cnt = (port_cnt > 3'(NUM_PORTS)) ? 3'(NUM_PORTS) : port_cnt;
		hit = 1'b0;
		hidx = '0;
		for (int k = 3; k >= 0; k--) begin
			if (k < NUM_PORTS && 3'(k) < cnt && ports[16*k +: 16] == dport) begin
				hit = 1'b1;
				hidx = 2'(k);
			end
		end
		j = '0;
		if (len < 12'(MIN_FRAME_BYTES) || len > 12'(MAX_FRAME_BYTES) || len < 12'(CapBytes)) begin
			j.res.verdict = V_BAD_SIZE;
		end else begin
			j.res.remote_mac = {h[6], h[7], h[8], h[9], h[10], h[11]};
			if (!((accept_mode[0] && {h[0], h[1], h[2], h[3], h[4], h[5]} == 48'hFFFF_FFFF_FFFF)
				|| (accept_mode[1] && {h[0], h[1], h[2], h[3], h[4], h[5]} == local_mac))) begin
				j.res.verdict = V_ADDR_MISS;
			end else if (etype == 16'h0800) begin
				if (h[14] != 8'h45 || h[15] != 8'h00 || h[21] != 8'h00
					|| !(h[20] == 8'h00 || h[20] == 8'h40)) begin
					j.res.verdict = V_IP_HDR;
				end else begin
					j.res.remote_ip = {h[26], h[27], h[28], h[29]};
					if ({h[30], h[31], h[32], h[33]} != local_ip) j.res.verdict = V_NOT_LOCAL;
					else if (h[23] == 8'd17) begin
						if (hit && ulen >= 16'd8 && total >= 16'd28
							&& (ulen - 16'd8) == (total - 16'd28)
							&& (total - 16'd28) <= 16'd2047) begin
							j.res.verdict = V_UDP_OK;
							j.res.remote_port = {h[34], h[35]};
							j.res.port_index = hidx;
							j.res.payload_length = 11'(total - 16'd28);
						end else j.res.verdict = V_UDP_MISS;
					end else if (h[23] == 8'd1) begin
						if (h[34] != 8'h08) j.res.verdict = V_ICMP_OTHER;
						else begin
							j.res.verdict = V_ICMP_ECHO;
							j.res.icmp_identifier = {h[38], h[39]};
							j.res.icmp_sequence = {h[40], h[41]};
						end
					end else j.res.verdict = V_OTHER_PROTO;
				end
			end else if (etype == 16'h0806) begin
				if ({h[14], h[15]} != 16'h0001 || {h[16], h[17]} != 16'h0800 || h[18] != 8'd6
					|| h[19] != 8'd4 || {h[38], h[39], h[40], h[41]} != local_ip) begin
					j.res.verdict = V_ARP_IGN;
				end else begin
					j.is_arp = 1'b1;
					j.res.verdict = V_ARP_IGN;
					j.arp_reply = ({h[20], h[21]} == 16'h0001);
					j.smac = {h[22], h[23], h[24], h[25], h[26], h[27]};
					j.sip = {h[28], h[29], h[30], h[31]};
				end
			end else j.res.verdict = V_OTHER_ETYPE;
		end
	end

	assign job_valid = in_acc && in_item.frame_end;
	assign job = j;
endmodule

// File: sv/eirc_queue.sv
// Two-entry job queue between front and back parts.
// Uses eirc_pkg and the assertion macros.
module eirc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  eirc_pkg::job_t push_job,
	output logic           full,
	output logic           not_empty,
	input  logic           pop,
	output eirc_pkg::job_t head
);
	import eirc_pkg::*;
	`include "ethernet_ipv4_rx_classifier_unit_macros.svh"

	job_t       mem_q [QDepth];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full = (cnt_q == 2'(QDepth));
	assign not_empty = (cnt_q != 2'd0);
	assign head = mem_q[rp_q];

	`EIRC_ASSERT_IMP(a_no_overflow, clk, arst_n, full, !push)
	`EIRC_ASSERT_IMP(a_no_underflow, clk, arst_n, !not_empty, !pop)
	`EIRC_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'(QDepth))
endmodule

// File: sv/eirc_back.sv
// Back part: ARP neighbour table search/update and the output register.
// Uses eirc_pkg and the assertion macros.
module eirc_back #(
	parameter int ARP_ENTRIES = eirc_pkg::ArpEntriesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  eirc_pkg::job_t    job,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output eirc_pkg::out_item_t out_item
);
	import eirc_pkg::*;
	`include "ethernet_ipv4_rx_classifier_unit_macros.svh"

	localparam int IW = (ARP_ENTRIES > 1) ? $clog2(ARP_ENTRIES) : 1;
	localparam int CW = $clog2(ARP_ENTRIES + 1);

	logic [31:0] nip_q [ARP_ENTRIES];
	logic [47:0] nmac_q [ARP_ENTRIES];
	logic [CW-1:0] ncnt_q, k_q;
	bk_state_t   st_q, st_d;
	out_item_t   res_q, res_d;
	logic        wr_en;
	logic [IW-1:0] wr_idx;
	logic        wr_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			ncnt_q <= '0;
			k_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == BK_IDLE) k_q <= '0;
			else if (st_q == BK_SEARCH) k_q <= k_q + CW'(1);
			if (wr_en && wr_new) ncnt_q <= ncnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (wr_en) begin
			nmac_q[wr_idx] <= job.smac;
			if (wr_new) nip_q[wr_idx] <= job.sip;
		end
	end

	// one neighbour entry compared per cycle
	always_comb begin
		st_d = st_q;
		res_d = res_q;
		job_pop = 1'b0;
		wr_en = 1'b0;
		wr_new = 1'b0;
		wr_idx = '0;
		case (st_q)
			BK_IDLE: begin
				if (job_valid) begin
					res_d = job.res;
					if (job.is_arp) st_d = BK_SEARCH;
					else begin
						job_pop = 1'b1;
						st_d = BK_OUT;
					end
				end
			end
			BK_SEARCH: begin
				if (k_q < ncnt_q) begin
					if (nip_q[k_q[IW-1:0]] == job.sip) begin
						wr_en = 1'b1;
						wr_idx = k_q[IW-1:0];
					end
				end else if (ncnt_q < CW'(ARP_ENTRIES)) begin
					wr_en = 1'b1;
					wr_new = 1'b1;
					wr_idx = ncnt_q[IW-1:0];
				end else begin
					res_d.arp_table_full = 1'b1;
					job_pop = 1'b1;
					st_d = BK_OUT;
				end
				if (wr_en) begin
					res_d.verdict = job.arp_reply ? V_ARP_REPLY : V_ARP_LEARN;
					res_d.remote_ip = job.sip;
					res_d.arp_index = 3'(wr_idx);
					job_pop = 1'b1;
					st_d = BK_OUT;
				end
			end
			BK_OUT: begin
				if (!out_stall) st_d = BK_IDLE;
			end
			default: st_d = BK_IDLE;
		endcase
	end

	assign out_valid = (st_q == BK_OUT);
	assign out_item = res_q;

	`EIRC_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_item))
	`EIRC_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, ncnt_q <= CW'(ARP_ENTRIES))
	`EIRC_ASSERT_IMP(a_pop_once, clk, arst_n, job_pop, st_d == BK_OUT)
endmodule

// File: sv/ethernet_ipv4_rx_classifier_unit.sv
// Ethernet/IPv4/ARP receive classifier, top level.
// Frame bytes enter on the in channel, one beat per byte, last byte flagged
// by frame_end. Each frame gives one verdict beat on the out channel, with
// source addresses, UDP, ICMP and ARP details as the verdict calls for.
// Configuration: cfg_we/cfg_index/cfg_data write one of eight registers
// (local MAC, local IP, accept mode, port count, four bound ports); write
// only while idle. Bytes are taken one per cycle unless stalled; the frame
// verdict is formed combinationally on the last byte and pushed into a
// two-entry queue. The back part compares one ARP table entry per cycle.
// Frame-end beats stall only while the queue is full; other bytes never
// stall. A stalled output holds its verdict. Reset clears the position
// counter, the queue and the ARP table fill count; table contents and
// captured header bytes stay as they were.
module ethernet_ipv4_rx_classifier_unit #(
	parameter int ARP_ENTRIES = eirc_pkg::ArpEntriesDef,
	parameter int MIN_FRAME_BYTES = eirc_pkg::MinFrameDef,
	parameter int MAX_FRAME_BYTES = eirc_pkg::MaxFrameDef,
	parameter int NUM_PORTS = eirc_pkg::NumPortsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  eirc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output eirc_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [3:0]          cfg_index,
	input  logic [47:0]         cfg_data
);
	import eirc_pkg::*;

	logic [47:0] mac_q;
	logic [31:0] ip_q;
	logic [1:0]  mode_q;
	logic [2:0]  pcnt_q;
	logic [63:0] ports_q;
	logic        in_acc, jv, qfull, qne, qpop;
	job_t        fjob, qhead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_q <= '0;
			ip_q <= '0;
			mode_q <= '0;
			pcnt_q <= '0;
			ports_q <= '0;
		end else if (cfg_we && !cfg_index[3]) begin
			case (reg_idx_t'(cfg_index[2:0]))
				R_LOCAL_MAC: mac_q <= cfg_data;
				R_LOCAL_IP: ip_q <= cfg_data[31:0];
				R_MODE: mode_q <= cfg_data[1:0];
				R_PORT_CNT: pcnt_q <= cfg_data[2:0];
				R_PORT0: ports_q[15:0] <= cfg_data[15:0];
				R_PORT1: ports_q[31:16] <= cfg_data[15:0];
				R_PORT2: ports_q[47:32] <= cfg_data[15:0];
				R_PORT3: ports_q[63:48] <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign in_stall = in_data.frame_end && qfull;
	assign in_acc = in_valid && !in_stall;

	eirc_front #(
		.MIN_FRAME_BYTES(MIN_FRAME_BYTES),
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES),
		.NUM_PORTS(NUM_PORTS)
	) u_front (
		.clk(clk), .arst_n(arst_n), .in_acc(in_acc), .in_item(in_data),
		.local_mac(mac_q), .local_ip(ip_q), .accept_mode(mode_q),
		.port_cnt(pcnt_q), .ports(ports_q), .job_valid(jv), .job(fjob)
	);

	eirc_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(jv), .push_job(fjob), .full(qfull),
		.not_empty(qne), .pop(qpop), .head(qhead)
	);

	eirc_back #(.ARP_ENTRIES(ARP_ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(qne), .job(qhead), .job_pop(qpop),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_data)
	);
endmodule
